>>> hdl/uqsp_pkg.sv
package uqsp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       has_value;
    logic       last;
  } out_item_t;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_PAIR  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;

  typedef enum logic [2:0] {
    PH_KEY   = 3'b001,
    PH_VALUE = 3'b010,
    PH_DROP  = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } esc_t;

  typedef struct packed {
    phase_t     phase;
    esc_t       esc;
    logic [3:0] high_nibble;
  } parse_state_t;

  typedef struct packed {
    parse_state_t state;
    logic         res_valid;
    out_item_t    res;
  } step_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_KEY, esc: ESC_NONE, high_nibble: 4'd0};

endpackage

>>> hdl/uqsp_step.sv
module uqsp_step
  import uqsp_pkg::*;
(
  input  in_item_t     item,
  input  parse_state_t cur,
  output step_t        step
);

  // {ok, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

  logic       in_pair;
  logic       in_value;
  logic [1:0] kind_here;
  logic [4:0] hex;

  assign in_value  = (cur.phase == PH_VALUE);
  assign in_pair   = (cur.phase == PH_KEY) || in_value;
  assign kind_here = in_value ? KIND_VALUE : KIND_KEY;
  assign hex       = hex_digit(item.in_byte);

  always_comb begin
    step.state     = cur;
    step.res_valid = 1'b0;
    step.res       = '0;
    if (item.is_end) begin
      step.state     = STATE_RESET;
      step.res_valid = 1'b1;
      step.res.last  = 1'b1;
      if (in_pair && cur.esc == ESC_NONE) begin
        step.res.out_kind  = KIND_PAIR;
        step.res.has_value = in_value;
      end else begin
        step.res.out_kind = KIND_BAD;
      end
    end else if (in_pair) begin
      if (cur.esc != ESC_NONE) begin
        if (!hex[4]) begin
          step.state.phase       = PH_DROP;
          step.state.esc         = ESC_NONE;
          step.state.high_nibble = 4'd0;
          step.res_valid         = 1'b1;
          step.res.out_kind      = KIND_BAD;
        end else if (cur.esc == ESC_HIGH) begin
          step.state.high_nibble = hex[3:0];
          step.state.esc         = ESC_LOW;
        end else begin
          step.state.esc         = ESC_NONE;
          step.state.high_nibble = 4'd0;
          step.res_valid         = 1'b1;
          step.res.out_byte      = {cur.high_nibble, hex[3:0]};
          step.res.out_kind      = kind_here;
        end
      end else if (item.in_byte == CH_PERCENT) begin
        step.state.esc = ESC_HIGH;
      end else if (item.in_byte == CH_AMP) begin
        step.state.phase   = PH_KEY;
        step.res_valid     = 1'b1;
        step.res.out_kind  = KIND_PAIR;
        step.res.has_value = in_value;
      end else if (item.in_byte == CH_EQUALS && !in_value) begin
        step.state.phase = PH_VALUE;
      end else begin
        step.res_valid    = 1'b1;
        step.res.out_byte = item.in_byte;
        step.res.out_kind = kind_here;
      end
    end
  end

endmodule

>>> hdl/url_query_stream_parser_unit.sv
// Streaming URL query decoder. Takes one raw byte (or an end marker) per cycle
// unless in_stall is high, and gives at most one result per byte: a decoded key
// or value byte, a pair-complete marker with has_value, or a malformed marker;
// last flags the result of the end marker. Sustained rate is one transaction
// per cycle on both channels while out_stall is low; a byte passes through the
// input register, then the result register; the state update between them is
// the only loop. Bytes that give no result ('%', the first hex digit, the first
// '=' of a key, dropped bytes) never wait for the result register.
module url_query_stream_parser_unit
  import uqsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic         s1_valid_r, s1_valid_nxt;
  in_item_t     s1_item_r;
  parse_state_t state_r;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r;
  step_t        step;
  logic         out_free;
  logic         s1_fire;
  logic         in_accept;

  uqsp_step u_step (
    .item (s1_item_r),
    .cur  (state_r),
    .step (step)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!step.res_valid || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && step.res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        state_r <= step.state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_fire && step.res_valid) begin
      out_data_r <= step.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_byte_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.out_kind == KIND_PAIR || out_data.out_kind == KIND_BAD)
      |-> out_data.out_byte == 8'd0)
    else $error("nonzero byte on a marker result");

  a_has_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_value |-> out_data.out_kind == KIND_PAIR)
    else $error("has_value on a non-pair result");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last
      |-> (out_data.out_kind == KIND_PAIR || out_data.out_kind == KIND_BAD))
    else $error("last on a data byte");

  a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.esc != ESC_NONE |-> state_r.phase != PH_DROP)
    else $error("escape pending while dropping");

endmodule
